[rtl/first_fit_heap_allocator_assert.svh]
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ffha_pkg.sv]
package ffha_pkg;

    // Default geometry
    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam logic [31:0] HEAP_BASE_RST = 32'h0010_0000;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 24;
    localparam int NEED_W = REQ_W + 1;
    localparam int ST_W   = 3;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFIT   = 3'd2;
    localparam logic [ST_W-1:0] ST_NULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

    // Table update broadcast to the cells
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ALLOC_WHOLE,
        CMD_ALLOC_SPLIT,
        CMD_FREE_ONLY,
        CMD_FREE_NEXT,
        CMD_FREE_PREV,
        CMD_FREE_BOTH
    } t_cmd_kind;

    typedef struct packed {
        logic      scan;       // register per-cell hit
        logic      scan_free;  // hit means address match, else fit
        logic      pick;       // register first-hit select
        t_cmd_kind kind;       // table update to apply
    } t_cell_ctl;

endpackage

[rtl/first_fit_heap_allocator.sv]
// One item in flight: a new item is accepted only in idle, once the last
// result is registered. Each item passes scan, pick, gather and apply; apply
// holds while a stalled result waits. The steps follow the row of block cells:
// compare, first-hit pick along the row, one-hot gather, one table shift step.
// Reset (synchronous, active low) leaves one free block of the whole heap
// minus one header, heap_base at 0x100000 and no result pending.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: heap_base
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // request_size[23:0], release_address[55:24]
    input  logic        s_axis_tuser,   // opcode[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // block_address[31:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int SW = $clog2(HEAP_BYTES + 1);
    localparam int N  = MAX_BLOCKS;
    localparam int EW = SW + 2;
    localparam int CW = ((SW > NEED_W) ? SW : NEED_W) + 2;
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [EW-1:0] HDR_E     = EW'(HEADER_BYTES);
    localparam logic [CW-1:0] SPLIT_E   = CW'(HEADER_BYTES + 4);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_GATHER, S_APPLY} t_state;

    t_state             r_state;
    logic [31:0]        r_heap_base;
    logic               r_op;
    logic               r_zero;
    logic               r_null;
    logic [NEED_W-1:0]  r_need;
    logic [ADDR_W-1:0]  r_off;
    logic               r_m_valid;
    logic [31:0]        r_m_addr;
    logic [ST_W-1:0]    r_m_status;

    // gathered view of the selected entry and its neighbors
    logic               r_g_found, n_g_found;
    logic [SW-1:0]      r_g_start, n_g_start;
    logic [SW-1:0]      r_g_size,  n_g_size;
    logic               r_g_free,  n_g_free;
    logic               r_g_pfree, n_g_pfree;
    logic [SW-1:0]      r_g_psize, n_g_psize;
    logic               r_g_nfree, n_g_nfree;
    logic [SW-1:0]      r_g_nsize, n_g_nsize;
    logic               r_g_full,  n_g_full;

    // row arrays padded with empty slots at both ends
    logic [SW-1:0]      x_start [N+3];
    logic [SW-1:0]      x_size  [N+3];
    logic               x_free  [N+3];
    logic               x_valid [N+3];
    logic               x_sel   [N+3];
    logic               x_chain [N+1];

    t_cell_ctl          w_ctl;
    t_cmd_kind          w_kind;
    logic [ST_W-1:0]    w_status;
    logic [31:0]        w_addr;
    logic [SW-1:0]      w_cmd_size;
    logic [SW-1:0]      w_cmd_start2;
    logic [SW-1:0]      w_cmd_size2;
    logic               w_go;
    logic               w_in_acc;
    logic [NEED_W-1:0]  w_need;
    logic [REQ_W-1:0]   w_req;
    logic [ADDR_W-1:0]  w_rel;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_req         = s_axis_tdata[REQ_W-1:0];
    assign w_rel         = s_axis_tdata[REQ_W +: ADDR_W];
    assign w_need        = (NEED_W'(w_req) + NEED_W'(3)) & ~NEED_W'(3);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_addr;
    assign m_axis_tuser  = r_m_status;

    assign w_go = !r_m_valid || m_axis_tready;

    // Empty slots around the row
    assign x_start[0]   = '0;
    assign x_size[0]    = '0;
    assign x_free[0]    = 1'b0;
    assign x_valid[0]   = 1'b0;
    assign x_sel[0]     = 1'b0;
    assign x_chain[0]   = 1'b0;
    assign x_start[N+1] = '0;
    assign x_size[N+1]  = '0;
    assign x_free[N+1]  = 1'b0;
    assign x_valid[N+1] = 1'b0;
    assign x_sel[N+1]   = 1'b0;
    assign x_start[N+2] = '0;
    assign x_size[N+2]  = '0;
    assign x_free[N+2]  = 1'b0;
    assign x_valid[N+2] = 1'b0;
    assign x_sel[N+2]   = 1'b0;

    // Row of block cells
    for (genvar j = 0; j < N; j++) begin : g_cell
        ffha_cell #(
            .SW        (SW),
            .IS_HEAD   (j == 0),
            .INIT_SIZE (INIT_SIZE)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_need       (r_need),
            .i_off        (r_off),
            .i_cmd_size   (w_cmd_size),
            .i_cmd_start2 (w_cmd_start2),
            .i_cmd_size2  (w_cmd_size2),
            .i_l_start    (x_start[j]),
            .i_l_size     (x_size[j]),
            .i_l_free     (x_free[j]),
            .i_l_valid    (x_valid[j]),
            .i_l_sel      (x_sel[j]),
            .i_chain      (x_chain[j]),
            .i_r_start    (x_start[j+2]),
            .i_r_size     (x_size[j+2]),
            .i_r_free     (x_free[j+2]),
            .i_r_valid    (x_valid[j+2]),
            .i_r_sel      (x_sel[j+2]),
            .i_r2_start   (x_start[j+3]),
            .i_r2_size    (x_size[j+3]),
            .i_r2_free    (x_free[j+3]),
            .i_r2_valid   (x_valid[j+3]),
            .o_start      (x_start[j+1]),
            .o_size       (x_size[j+1]),
            .o_free       (x_free[j+1]),
            .o_valid      (x_valid[j+1]),
            .o_sel        (x_sel[j+1]),
            .o_chain      (x_chain[j+1])
        );
    end

    // Collect the selected entry and its neighbors (one-hot OR)
    always_comb begin
        n_g_found = 1'b0;
        n_g_start = '0;
        n_g_size  = '0;
        n_g_free  = 1'b0;
        n_g_pfree = 1'b0;
        n_g_psize = '0;
        n_g_nfree = 1'b0;
        n_g_nsize = '0;
        n_g_full  = x_valid[N];
        for (int j = 1; j <= N; j++) begin
            if (x_sel[j]) begin
                n_g_found = 1'b1;
                n_g_start = n_g_start | x_start[j];
                n_g_size  = n_g_size  | x_size[j];
                n_g_free  = n_g_free  | x_free[j];
            end
            if (x_sel[j+1] && x_valid[j] && x_free[j]) begin
                n_g_pfree = 1'b1;
                n_g_psize = n_g_psize | x_size[j];
            end
            if (x_sel[j-1] && x_valid[j] && x_free[j]) begin
                n_g_nfree = 1'b1;
                n_g_nsize = n_g_nsize | x_size[j];
            end
        end
    end

    // Decide result and table update
    always_comb begin
        w_kind       = CMD_NONE;
        w_status     = ST_OK;
        w_addr       = '0;
        w_cmd_size   = r_g_size;
        w_cmd_start2 = SW'(EW'(r_g_start) + HDR_E + EW'(r_need));
        w_cmd_size2  = SW'(EW'(r_g_size) - EW'(r_need) - HDR_E);
        if (r_op == OP_ALLOC) begin
            if (r_zero) begin
                w_status = ST_ZERO;
            end else if (!r_g_found) begin
                w_status = ST_NOFIT;
            end else begin
                w_cmd_size = SW'(r_need);
                w_addr     = r_heap_base + 32'(r_g_start) + 32'(HEADER_BYTES);
                if ((CW'(r_g_size) >= CW'(r_need) + SPLIT_E) && !r_g_full) begin
                    w_kind = CMD_ALLOC_SPLIT;
                end else begin
                    w_kind = CMD_ALLOC_WHOLE;
                end
            end
        end else begin
            if (r_null) begin
                w_status = ST_NULL;
            end else if (!r_g_found) begin
                w_status = ST_UNKNOWN;
            end else if (!r_g_free) begin
                if (r_g_pfree && r_g_nfree) begin
                    w_kind     = CMD_FREE_BOTH;
                    w_cmd_size = SW'(EW'(r_g_psize) + EW'(r_g_size) + EW'(r_g_nsize)
                                     + HDR_E + HDR_E);
                end else if (r_g_pfree) begin
                    w_kind     = CMD_FREE_PREV;
                    w_cmd_size = SW'(EW'(r_g_psize) + EW'(r_g_size) + HDR_E);
                end else if (r_g_nfree) begin
                    w_kind     = CMD_FREE_NEXT;
                    w_cmd_size = SW'(EW'(r_g_size) + EW'(r_g_nsize) + HDR_E);
                end else begin
                    w_kind = CMD_FREE_ONLY;
                end
            end
        end
    end

    // Cell control for the current phase
    always_comb begin
        w_ctl.scan      = (r_state == S_SCAN);
        w_ctl.scan_free = (r_op == OP_FREE);
        w_ctl.pick      = (r_state == S_PICK);
        w_ctl.kind      = ((r_state == S_APPLY) && w_go) ? w_kind : CMD_NONE;
    end

    // Sequencer, request registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_base <= HEAP_BASE_RST;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_heap_base <= i_cfg_data;
            if (r_m_valid && m_axis_tready) r_m_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= s_axis_tuser;
                        r_zero  <= (w_req == '0);
                        r_null  <= (w_rel == '0);
                        r_need  <= w_need;
                        r_off   <= w_rel - r_heap_base - ADDR_W'(HEADER_BYTES);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN:   r_state <= S_PICK;
                S_PICK:   r_state <= S_GATHER;
                S_GATHER: begin
                    r_g_found <= n_g_found;
                    r_g_start <= n_g_start;
                    r_g_size  <= n_g_size;
                    r_g_free  <= n_g_free;
                    r_g_pfree <= n_g_pfree;
                    r_g_psize <= n_g_psize;
                    r_g_nfree <= n_g_nfree;
                    r_g_nsize <= n_g_nsize;
                    r_g_full  <= n_g_full;
                    r_state   <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_go) begin
                        r_m_valid  <= 1'b1;
                        r_m_addr   <= w_addr;
                        r_m_status <= w_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/ffha_cell.sv]
// One table entry: holds a block, tests it against a request and shifts
// entries with its neighbors on insert and merge.
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int              SW        = 21,
    parameter bit              IS_HEAD   = 1'b0,
    parameter logic [SW-1:0]   INIT_SIZE = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [NEED_W-1:0] i_need,
    input  logic [ADDR_W-1:0] i_off,
    input  logic [SW-1:0]     i_cmd_size,
    input  logic [SW-1:0]     i_cmd_start2,
    input  logic [SW-1:0]     i_cmd_size2,
    // left neighbor (lower index)
    input  logic [SW-1:0]     i_l_start,
    input  logic [SW-1:0]     i_l_size,
    input  logic              i_l_free,
    input  logic              i_l_valid,
    input  logic              i_l_sel,
    input  logic              i_chain,
    // right neighbor
    input  logic [SW-1:0]     i_r_start,
    input  logic [SW-1:0]     i_r_size,
    input  logic              i_r_free,
    input  logic              i_r_valid,
    input  logic              i_r_sel,
    // neighbor two places right
    input  logic [SW-1:0]     i_r2_start,
    input  logic [SW-1:0]     i_r2_size,
    input  logic              i_r2_free,
    input  logic              i_r2_valid,
    // own state
    output logic [SW-1:0]     o_start,
    output logic [SW-1:0]     o_size,
    output logic              o_free,
    output logic              o_valid,
    output logic              o_sel,
    output logic              o_chain
);

    localparam int CW = ((SW > NEED_W) ? SW : NEED_W) + 1;

    logic [SW-1:0] r_start, n_start;
    logic [SW-1:0] r_size,  n_size;
    logic          r_free,  n_free;
    logic          r_valid, n_valid;
    logic          r_hit;
    logic          r_sel;
    logic          r_aft;
    logic          w_hit;

    // Test this entry against the request
    always_comb begin
        if (i_ctl.scan_free) begin
            w_hit = r_valid && (ADDR_W'(r_start) == i_off);
        end else begin
            w_hit = r_valid && r_free && (CW'(r_size) >= CW'(i_need));
        end
    end

    // Pass "hit seen" toward higher entries
    assign o_chain = i_chain | r_hit;

    // Apply the broadcast update
    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        n_free  = r_free;
        n_valid = r_valid;
        case (i_ctl.kind)
            CMD_ALLOC_WHOLE: begin
                if (r_sel) n_free = 1'b0;
            end
            CMD_ALLOC_SPLIT: begin
                if (r_sel) begin
                    n_size = i_cmd_size;
                    n_free = 1'b0;
                end else if (i_l_sel) begin
                    n_start = i_cmd_start2;
                    n_size  = i_cmd_size2;
                    n_free  = 1'b1;
                    n_valid = 1'b1;
                end else if (r_aft) begin
                    n_start = i_l_start;
                    n_size  = i_l_size;
                    n_free  = i_l_free;
                    n_valid = i_l_valid;
                end
            end
            CMD_FREE_ONLY: begin
                if (r_sel) n_free = 1'b1;
            end
            CMD_FREE_NEXT: begin
                if (r_sel) begin
                    n_size = i_cmd_size;
                    n_free = 1'b1;
                end else if (r_aft) begin
                    n_start = i_r_start;
                    n_size  = i_r_size;
                    n_free  = i_r_free;
                    n_valid = i_r_valid;
                end
            end
            CMD_FREE_PREV: begin
                if (i_r_sel) begin
                    n_size = i_cmd_size;
                end else if (r_sel || r_aft) begin
                    n_start = i_r_start;
                    n_size  = i_r_size;
                    n_free  = i_r_free;
                    n_valid = i_r_valid;
                end
            end
            CMD_FREE_BOTH: begin
                if (i_r_sel) begin
                    n_size = i_cmd_size;
                end else if (r_sel || r_aft) begin
                    n_start = i_r2_start;
                    n_size  = i_r2_size;
                    n_free  = i_r2_free;
                    n_valid = i_r2_valid;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold entry and per-request flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_size  <= IS_HEAD ? INIT_SIZE : '0;
            r_free  <= IS_HEAD;
            r_valid <= IS_HEAD;
            r_hit   <= 1'b0;
            r_sel   <= 1'b0;
            r_aft   <= 1'b0;
        end else begin
            r_start <= n_start;
            r_size  <= n_size;
            r_free  <= n_free;
            r_valid <= n_valid;
            if (i_ctl.scan) r_hit <= w_hit;
            if (i_ctl.pick) begin
                r_sel <= r_hit & ~i_chain;
                r_aft <= i_chain;
            end
        end
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_free  = r_free;
    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

[rtl/ffha_checker.sv]
`include "first_fit_heap_allocator_assert.svh"

// Port-level checks on the allocator.
module ffha_checker
    import ffha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result item holds
    `FFHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Any failure reports address zero
    `FFHA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "failure with nonzero address")

    // No result is produced in the cycle right after an item is accepted
    `FFHA_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid && !s_axis_tready, "result too early")

    // Status stays within the defined codes
    `FFHA_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= ST_UNKNOWN, "status out of range")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
